// ===== design/udc_pkg.sv =====
// Shared types, widths and constants of the debounced up/down counter.
// Used by every module in design/; depends on nothing.
package udc_pkg;

  localparam int CNT_W      = 27;
  localparam int BCD_DIGITS = 8;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int SEL_W      = 8;
  localparam int SEG_W      = 7;
  localparam int TICK_W     = 16;
  localparam int SCAN_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DWELL    = 2'd1;

  localparam logic [TICK_W-1:0] DEBOUNCE_RESET = 16'd20;
  localparam logic [TICK_W-1:0] DWELL_RESET    = 16'd5;

  localparam logic [CNT_W-1:0] COUNT_MAX   = 27'd99999999;
  localparam logic [CNT_W-1:0] COUNT_RESET = 27'd31415926;
  localparam logic [BCD_W-1:0] BCD_RESET   = 32'h31415926;

  typedef struct packed {
    logic dec;
    logic inc;
  } step_t;

  function automatic logic [SEG_W-1:0] seg_decode(input logic [3:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

// ===== design/udc_in_if.sv =====
// Input channel: one button sample word per tick.
// Depends on nothing.
interface udc_in_if;
  logic valid;
  logic ready;
  logic down_pressed;
  logic up_pressed;

  modport source (output valid, output down_pressed, output up_pressed, input ready);
  modport sink   (input valid, input down_pressed, input up_pressed, output ready);
endinterface

// ===== design/udc_out_if.sv =====
// Result channel: display scan and count word per tick.
// Depends on udc_pkg for field widths.
interface udc_out_if;
  logic                         valid;
  logic                         ready;
  logic [udc_pkg::SEL_W-1:0]    digit_select;
  logic [udc_pkg::SEG_W-1:0]    segments;
  logic [udc_pkg::CNT_W-1:0]    count_value;

  modport source (output valid, output digit_select, output segments, output count_value,
                  input ready);
  modport sink   (input valid, input digit_select, input segments, input count_value,
                  output ready);
endinterface

// ===== design/udc_qualifier.sv =====
// Press qualifier for one button: idle, wait out the debounce time, held.
// Depends on udc_pkg for the tick width.
module udc_qualifier (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        level,
  input  logic [udc_pkg::TICK_W-1:0]  debounce_ticks,
  output logic                        act
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_WAIT = 2'd1;
  localparam logic [1:0] PH_HELD = 2'd2;

  logic [1:0]                  phase_r, phase_nxt;
  logic [udc_pkg::TICK_W-1:0]  timer_r, timer_nxt, timer_dec;

  always_comb begin
    phase_nxt = phase_r;
    timer_nxt = timer_r;
    act       = 1'b0;
    timer_dec = (timer_r != '0) ? timer_r - 1'b1 : timer_r;
    unique case (phase_r)
      PH_WAIT: begin
        timer_nxt = timer_dec;
        if (timer_dec == '0) begin
          if (level) begin
            phase_nxt = PH_HELD;
            act       = 1'b1;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
      end
      PH_HELD: begin
        if (!level) phase_nxt = PH_IDLE;
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (level) begin
          phase_nxt = PH_WAIT;
          timer_nxt = (debounce_ticks != '0) ? debounce_ticks : udc_pkg::TICK_W'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      timer_r <= '0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      timer_r <= timer_nxt;
    end
  end

endmodule

// ===== design/udc_counter.sv =====
// Saturating up/down counter kept in binary and in BCD side by side.
// Depends on udc_pkg for widths, limits and the step_t struct.
module udc_counter (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  udc_pkg::step_t             step,
  output logic [udc_pkg::CNT_W-1:0]  count_nxt,
  output logic [udc_pkg::BCD_W-1:0]  bcd_nxt
);

  logic [udc_pkg::CNT_W-1:0]  count_r;
  logic [udc_pkg::BCD_W-1:0]  bcd_r;
  logic                       at_zero, at_max, do_inc, do_dec;

  function automatic logic [udc_pkg::BCD_W-1:0] bcd_inc(input logic [udc_pkg::BCD_W-1:0] v);
    logic [udc_pkg::BCD_W-1:0] r;
    logic                      c;
    logic [3:0]                d;
    r = v;
    c = 1'b1;
    for (int i = 0; i < udc_pkg::BCD_DIGITS; i++) begin
      d = v[4*i +: 4];
      if (c) begin
        if (d == 4'd9) begin
          r[4*i +: 4] = 4'd0;
        end else begin
          r[4*i +: 4] = d + 4'd1;
          c = 1'b0;
        end
      end
    end
    return r;
  endfunction

  function automatic logic [udc_pkg::BCD_W-1:0] bcd_dec(input logic [udc_pkg::BCD_W-1:0] v);
    logic [udc_pkg::BCD_W-1:0] r;
    logic                      b;
    logic [3:0]                d;
    r = v;
    b = 1'b1;
    for (int i = 0; i < udc_pkg::BCD_DIGITS; i++) begin
      d = v[4*i +: 4];
      if (b) begin
        if (d == 4'd0) begin
          r[4*i +: 4] = 4'd9;
        end else begin
          r[4*i +: 4] = d - 4'd1;
          b = 1'b0;
        end
      end
    end
    return r;
  endfunction

  // Both presses on one tick cancel except at zero, where only the increment lands.
  always_comb begin
    at_zero = (count_r == '0);
    at_max  = (count_r == udc_pkg::COUNT_MAX);
    do_inc  = 1'b0;
    do_dec  = 1'b0;
    if (step.dec && step.inc) begin
      do_inc = at_zero;
    end else if (step.dec) begin
      do_dec = !at_zero;
    end else if (step.inc) begin
      do_inc = !at_max;
    end
    if (do_inc) begin
      count_nxt = count_r + 1'b1;
      bcd_nxt   = bcd_inc(bcd_r);
    end else if (do_dec) begin
      count_nxt = count_r - 1'b1;
      bcd_nxt   = bcd_dec(bcd_r);
    end else begin
      count_nxt = count_r;
      bcd_nxt   = bcd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= udc_pkg::COUNT_RESET;
      bcd_r   <= udc_pkg::BCD_RESET;
    end else if (adv) begin
      count_r <= count_nxt;
      bcd_r   <= bcd_nxt;
    end
  end

endmodule

// ===== design/debounced_updown_counter_led_scan_core.sv =====
// Top level of the debounced up/down counter with seven-segment scan.
// Depends on udc_pkg, udc_in_if, udc_out_if, udc_qualifier and udc_counter.
//
// Usage:
//   in_if carries one word per time tick: the down and up button levels.
//   out_if returns one word per input word: active-low digit select, the
//   segment pattern of the selected digit and the count after that tick.
//   cfg_we/cfg_index/cfg_data write debounce_ticks (index 0) and
//   dwell_ticks (index 1); other indexes are dropped. Write only while idle.
// Path: an accepted word sits in the input register; the result register
//   loads from it once the output side is free (out_valid low or out_if.ready).
// Throughput: one word per cycle while out_if.ready is high; the per-tick update
//   of qualifiers, counter and scan position is a single pass between the two registers.
// Reset: count 31415926, both qualifiers idle, scan at the most
//   significant digit, debounce 20 and dwell 5 ticks. No clearing pass.
// Stall: while out_if.ready is low the result holds; the input register
//   still takes one more word, then in_if.ready drops.
module debounced_updown_counter_led_scan_core #(
  parameter int NUM_DIGITS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  udc_in_if.sink                             in_if,
  udc_out_if.source                          out_if,
  input  logic                               cfg_we,
  input  logic [udc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [udc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int SW = udc_pkg::SCAN_W;
  localparam logic [SW:0]   NUM_LIM  = (SW+1)'(NUM_DIGITS);
  localparam logic [SW-1:0] LAST_POS = SW'(NUM_DIGITS - 1);

  logic [udc_pkg::TICK_W-1:0]  debounce_r, dwell_r;
  logic                        in_valid_r, down_r, up_r;
  logic                        out_valid_r;
  logic [udc_pkg::SEL_W-1:0]   sel_r;
  logic [udc_pkg::SEG_W-1:0]   seg_r;
  logic [udc_pkg::CNT_W-1:0]   cnt_r;
  logic [SW-1:0]               scan_r, scan_nxt, pos, place;
  logic [udc_pkg::TICK_W-1:0]  dwell_timer_r, dwell_timer_nxt, dwell_lim;
  logic [SW:0]                 pos_inc;
  logic [udc_pkg::TICK_W:0]    dwell_sum;
  logic                        s2_free, adv, in_take;
  udc_pkg::step_t              step;
  logic [udc_pkg::CNT_W-1:0]   count_nxt;
  logic [udc_pkg::BCD_W-1:0]   bcd_nxt;
  logic [3:0]                  digit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= udc_pkg::DEBOUNCE_RESET;
      dwell_r    <= udc_pkg::DWELL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        udc_pkg::REG_DEBOUNCE: debounce_r <= cfg_data;
        udc_pkg::REG_DWELL:    dwell_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s2_free     = !out_valid_r || out_if.ready;
  assign adv         = in_valid_r && s2_free;
  assign in_if.ready = !in_valid_r || adv;
  assign in_take     = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      down_r <= in_if.down_pressed;
      up_r   <= in_if.up_pressed;
    end
  end

  udc_qualifier u_qual_down (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .level          (down_r),
    .debounce_ticks (debounce_r),
    .act            (step.dec)
  );

  udc_qualifier u_qual_up (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .level          (up_r),
    .debounce_ticks (debounce_r),
    .act            (step.inc)
  );

  udc_counter u_counter (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .step      (step),
    .count_nxt (count_nxt),
    .bcd_nxt   (bcd_nxt)
  );

  always_comb begin
    pos             = ({1'b0, scan_r} >= NUM_LIM) ? '0 : scan_r;
    place           = LAST_POS - pos;
    digit           = bcd_nxt[{place, 2'b00} +: 4];
    pos_inc         = {1'b0, pos} + 1'b1;
    dwell_lim       = (dwell_r != '0) ? dwell_r : udc_pkg::TICK_W'(1);
    dwell_sum       = {1'b0, dwell_timer_r} + 1'b1;
    dwell_timer_nxt = dwell_sum[udc_pkg::TICK_W-1:0];
    scan_nxt        = pos;
    if (dwell_sum >= {1'b0, dwell_lim}) begin
      dwell_timer_nxt = '0;
      scan_nxt        = (pos_inc >= NUM_LIM) ? '0 : pos_inc[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r        <= '0;
      dwell_timer_r <= '0;
    end else if (adv) begin
      scan_r        <= scan_nxt;
      dwell_timer_r <= dwell_timer_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sel_r <= ~(udc_pkg::SEL_W'(1) << pos);
      seg_r <= udc_pkg::seg_decode(digit);
      cnt_r <= count_nxt;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.digit_select = sel_r;
  assign out_if.segments     = seg_r;
  assign out_if.count_value  = cnt_r;

endmodule
